/* design/time_window_reorder_buffer_macros.svh */
// ----------------------------------------------------------------------------
// time_window_reorder_buffer_macros
// Assertion macros used by the reorder buffer back end.
// ----------------------------------------------------------------------------
`ifndef TIME_WINDOW_REORDER_BUFFER_MACROS_SVH
`define TIME_WINDOW_REORDER_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TWRB_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("reorder buffer check failed");
// next-cycle implication
`define TWRB_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("reorder buffer check failed");
`else
`define TWRB_ASSERT_IMP(lbl, ant, cons)
`define TWRB_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

/* design/twrb_pkg.sv */
// ----------------------------------------------------------------------------
// twrb_pkg
// Types and constants of the time window reorder buffer.
// ----------------------------------------------------------------------------
package twrb_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int TIME_BITS   = 48;
    localparam int WORD_BITS   = 64;
    localparam int WIN_BITS    = 24;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W       = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(256);

    // record kinds
    localparam logic [1:0] FUNC_HIT         = 2'd0;
    localparam logic [1:0] FUNC_SPILL_START = 2'd1;
    localparam logic [1:0] FUNC_SPILL_END   = 2'd2;
    localparam logic [1:0] FUNC_OTHER       = 2'd3;

    // classes assigned by the front part
    localparam logic [1:0] CLS_HIT   = 2'd0;
    localparam logic [1:0] CLS_SPILL = 2'd1;
    localparam logic [1:0] CLS_OTHER = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [TIME_BITS-1:0] time_stamp;
        logic [WORD_BITS-1:0] record_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           out_kind;
        logic [TIME_BITS-1:0] out_time;
        logic [WORD_BITS-1:0] out_word;
        logic                 forced_out;
        logic                 last_of_run;
    } out_item_t;

    typedef struct packed {
        in_item_t   item;
        logic [1:0] cls;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

endpackage

/* design/time_window_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// time_window_reorder_buffer
// Reorders timestamped records by time inside a configurable window.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take input words (func, time_stamp, record_word).
//   m_valid/m_ready/m_data deliver result words; last_of_run marks the final
//   word caused by one input. cfg_wr_en/cfg_wr_data write the window
//   (24 bits, 256 after reset); write it only while the block is idle.
//   A two-entry queue takes words while the back end works. A hit is inserted
//   into the sorted cell chain, after an eviction when the chain is full, and
//   then releases the words that fall behind the window; a spill marker first
//   flushes every word and is then sent itself; other records are sent as they
//   are. The chain shifts by one cell per release, which sets the rate.
//   Results reach m_data via the queue, the sequencer and the output register.
//   Reset empties the chain and queue and clears the running maximum.
//   When m_ready is low the output register holds its word and the back end
//   waits; the queue keeps taking input until its two entries are full.
// ----------------------------------------------------------------------------
module time_window_reorder_buffer import twrb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [WIN_BITS-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data
);

    logic [WIN_BITS-1:0] window_reg;
    q_head_t             q_head;
    logic                q_pop;

    // window register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    twrb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    twrb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .window  (window_reg),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* design/twrb_front.sv */
// ----------------------------------------------------------------------------
// twrb_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module twrb_front import twrb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output q_head_t  q_head,
    input  logic     q_pop
);

    q_entry_t   ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    logic [1:0] cls;

    // classify incoming word
    always_comb begin
        case (s_data.func)
            FUNC_HIT:         cls = CLS_HIT;
            FUNC_SPILL_START: cls = CLS_SPILL;
            FUNC_SPILL_END:   cls = CLS_SPILL;
            default:          cls = CLS_OTHER;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (cnt_reg != 2'd0);

    assign q_head.valid = (cnt_reg != 2'd0);
    assign q_head.entry = ent_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= '{item: s_data, cls: cls};
        end
    end

endmodule

/* design/twrb_back.sv */
// ----------------------------------------------------------------------------
// twrb_back
// Sorted cell chain with release, forced eviction and flush sequencing.
// ----------------------------------------------------------------------------
`include "time_window_reorder_buffer_macros.svh"
module twrb_back import twrb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [WIN_BITS-1:0] window,
    input  q_head_t             q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FORCE   = 3'd1;
    localparam logic [2:0] ST_INSERT  = 3'd2;
    localparam logic [2:0] ST_RELEASE = 3'd3;
    localparam logic [2:0] ST_FLUSH   = 3'd4;
    localparam logic [2:0] ST_MARK    = 3'd5;

    logic [2:0]           state_reg, state_next;
    q_entry_t             cur_reg, cur_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_BITS-1:0] max_reg, max_next;
    logic [TIME_BITS-1:0] limit_reg, limit_next;
    logic                 lim_ok_reg, lim_ok_next;
    logic [TIME_BITS-1:0] time_reg [STORE_DEPTH];
    logic [WORD_BITS-1:0] word_reg [STORE_DEPTH];
    logic [TIME_BITS-1:0] time_next [STORE_DEPTH];
    logic [WORD_BITS-1:0] word_next [STORE_DEPTH];
    logic                 gt [STORE_DEPTH];
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;
    logic                 out_free;
    logic                 do_pop, do_ins;
    logic [TIME_BITS-1:0] new_max;
    logic [TIME_BITS-1:0] force_max;
    logic [TIME_BITS-1:0] force_head;
    logic [CMP_W-1:0]     diff;
    logic [CMP_W-1:0]     force_diff;
    logic                 force_more;
    logic                 head_elig;
    logic                 next_elig;
    logic [TIME_BITS-1:0] cur_time;

    assign cur_time = cur_reg.item.time_stamp;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // insert position: cells later than the new word
    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < count_reg) && (time_reg[i] > cur_time);
        end
    end

    // new running maximum and release limit
    always_comb begin
        new_max = ((count_reg == '0) || (cur_time > max_reg)) ? cur_time : max_reg;
        diff    = CMP_W'(new_max) - CMP_W'(window);
    end

    // release check after a forced eviction, to mark the last word
    always_comb begin
        force_max  = (cur_time > max_reg) ? cur_time : max_reg;
        force_head = (time_reg[1] <= cur_time) ? time_reg[1] : cur_time;
        force_diff = CMP_W'(force_max) - CMP_W'(window);
        force_more = (CMP_W'(force_max) >= CMP_W'(window))
                     && (CMP_W'(force_head) <= force_diff);
    end

    assign head_elig = (count_reg != '0) && lim_ok_reg && (time_reg[0] <= limit_reg);
    assign next_elig = (count_reg > CNT_W'(1)) && (time_reg[1] <= limit_reg);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        max_next     = max_reg;
        limit_next   = limit_reg;
        lim_ok_next  = lim_ok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        do_pop       = 1'b0;
        do_ins       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_head.valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_head.entry;
                    case (q_head.entry.cls)
                        CLS_HIT: begin
                            state_next = (count_reg == CNT_W'(STORE_DEPTH)) ? ST_FORCE
                                                                            : ST_INSERT;
                        end
                        CLS_SPILL: state_next = ST_FLUSH;
                        default:   state_next = ST_MARK;
                    endcase
                end
            end
            ST_FORCE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_kind: FUNC_HIT, out_time: time_reg[0],
                                     out_word: word_reg[0], forced_out: 1'b1,
                                     last_of_run: !force_more};
                    do_pop       = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                    state_next   = ST_INSERT;
                end
            end
            ST_INSERT: begin
                do_ins      = 1'b1;
                count_next  = count_reg + CNT_W'(1);
                max_next    = new_max;
                lim_ok_next = CMP_W'(new_max) >= CMP_W'(window);
                limit_next  = TIME_BITS'(diff);
                state_next  = ST_RELEASE;
            end
            ST_RELEASE: begin
                if (!head_elig) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_kind: FUNC_HIT, out_time: time_reg[0],
                                     out_word: word_reg[0], forced_out: 1'b0,
                                     last_of_run: !next_elig};
                    do_pop       = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            ST_FLUSH: begin
                if (count_reg == '0) begin
                    state_next = ST_MARK;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_kind: FUNC_HIT, out_time: time_reg[0],
                                     out_word: word_reg[0], forced_out: 1'b0,
                                     last_of_run: 1'b0};
                    do_pop       = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_kind: cur_reg.item.func, out_time: cur_time,
                                     out_word: cur_reg.item.record_word,
                                     forced_out: 1'b0, last_of_run: 1'b1};
                    if (cur_reg.cls == CLS_SPILL) begin
                        max_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // cell chain: shift down on pop, open a slot on insert
    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            time_next[i] = time_reg[i];
            word_next[i] = word_reg[i];
        end
        if (do_pop) begin
            for (int i = 0; i < STORE_DEPTH - 1; i++) begin
                time_next[i] = time_reg[i + 1];
                word_next[i] = word_reg[i + 1];
            end
        end else if (do_ins) begin
            // new word lands at the first later cell or at the end
            for (int i = 0; i < STORE_DEPTH; i++) begin
                if (gt[i] || (CNT_W'(i) == count_reg)) begin
                    time_next[i] = cur_time;
                    word_next[i] = cur_reg.item.record_word;
                end
            end
            // later cells move up by one
            for (int i = 1; i < STORE_DEPTH; i++) begin
                if (gt[i - 1]) begin
                    time_next[i] = time_reg[i - 1];
                    word_next[i] = word_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            max_reg     <= '0;
            lim_ok_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            max_reg     <= max_next;
            lim_ok_reg  <= lim_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        limit_reg  <= limit_next;
        m_data_reg <= m_data_next;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            time_reg[i] <= time_next[i];
            word_reg[i] <= word_next[i];
        end
    end

    `TWRB_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(STORE_DEPTH))
    `TWRB_ASSERT_IMP(a_head_sorted, count_reg > CNT_W'(1), time_reg[0] <= time_reg[1])
    `TWRB_ASSERT_IMP(a_force_full, state_reg == ST_FORCE, count_reg == CNT_W'(STORE_DEPTH))
    `TWRB_ASSERT_NXT(a_flush_done, state_reg == ST_FLUSH && count_reg == '0, state_reg == ST_MARK)

endmodule
